/* rtl/nested_region_time_profiler_core_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the nested region time profiler
// ---------------------------------------------------------------------------
`ifndef NESTED_REGION_TIME_PROFILER_CORE_DEFINES_SVH
`define NESTED_REGION_TIME_PROFILER_CORE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define NRTP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nrtp check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define NRTP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nrtp check failed");

`endif

/* rtl/nrtp_pkg.sv */
// ---------------------------------------------------------------------------
// nrtp_pkg
// Shared types, widths and helpers of the nested region time profiler.
// ---------------------------------------------------------------------------
`default_nettype none

package nrtp_pkg;

    // default sizing
    localparam int DEF_NUM_BUCKETS = 16;
    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_TIME_BITS   = 32;

    // fixed field widths
    localparam int BKT_IN_W  = 4;
    localparam int TIME_IN_W = 32;
    localparam int TICK_W    = 48;
    localparam int CALL_W    = 32;
    localparam int DEPTH_W   = 8;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
    localparam logic [TICK_W-1:0]  TICKS_MAX = '1;
    localparam logic [CALL_W-1:0]  CALLS_MAX = '1;

    // request codes
    typedef enum logic [1:0] {
        REQ_BEGIN = 2'd0,
        REQ_END   = 2'd1,
        REQ_COUNT = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_STK,
        S_BILL,
        S_CALL_RD,
        S_CALL,
        S_RESP
    } t_state;

    // bucket memory port controls
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_bkt_ctl;

    // bucket index modulo a bucket count of two or more (input is below 16)
    function automatic logic [7:0] bkt_wrap(input logic [BKT_IN_W-1:0] b,
                                            input int unsigned n);
        logic [7:0] r;
        r = 8'(b);
        for (int k = 0; k < 8; k++) begin
            if (32'(r) >= n) begin
                r = r - 8'(n);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/nrtp_bkt_mem.sv */
// ---------------------------------------------------------------------------
// nrtp_bkt_mem
// Per-bucket tick and call totals: one read and one write port, registered
// read data, valid bits so that every entry reads as zero after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module nrtp_bkt_mem
    import nrtp_pkg::*;
#(
    parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
    parameter int BW          = $clog2(NUM_BUCKETS)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_bkt_ctl          i_ctl,
    input  wire logic [BW-1:0]     i_rd_addr,
    input  wire logic [BW-1:0]     i_wr_addr,
    input  wire logic [TICK_W-1:0] i_wr_ticks,
    input  wire logic [CALL_W-1:0] i_wr_calls,
    output logic      [TICK_W-1:0] o_rd_ticks,
    output logic      [CALL_W-1:0] o_rd_calls
);

    logic [TICK_W-1:0]      r_mem_ticks [NUM_BUCKETS];
    logic [CALL_W-1:0]      r_mem_calls [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] r_valid;
    logic [TICK_W-1:0]      r_rd_ticks;
    logic [CALL_W-1:0]      r_rd_calls;
    logic                   r_rd_valid;

    // entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem_ticks[i_wr_addr] <= i_wr_ticks;
            r_mem_calls[i_wr_addr] <= i_wr_calls;
        end
        if (i_ctl.rd_en) begin
            r_rd_ticks <= r_mem_ticks[i_rd_addr];
            r_rd_calls <= r_mem_calls[i_rd_addr];
        end
    end

    // never-written entries read as zero
    assign o_rd_ticks = r_rd_valid ? r_rd_ticks : '0;
    assign o_rd_calls = r_rd_valid ? r_rd_calls : '0;

endmodule

`default_nettype wire

/* rtl/nested_region_time_profiler_core.sv */
// Nested region profiler: words carry begin, end, count and read requests.
// Begin and end bill the ticks elapsed since the innermost open region's
// start to that region's bucket; reads return one word of totals. One word
// is taken at a time. At depth zero or past the stack, a begin only counts
// the call and an end bills nothing. Read requests take longer while the
// output word is stalled. Billing and counting are read-modify-writes of
// the bucket memory through its read and write ports, which a begin with
// an open region in the stack uses twice (bill the paused parent, then
// count the call), after one read of the stack memory.
// ---------------------------------------------------------------------------
// nested_region_time_profiler_core
// Top level: request sequencer, region stack memory and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module nested_region_time_profiler_core
    import nrtp_pkg::*;
#(
    parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [1:0]           i_req_type,
    input  wire logic [BKT_IN_W-1:0]  i_bucket,
    input  wire logic [TIME_IN_W-1:0] i_time_now,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic      [BKT_IN_W-1:0]  o_bucket_out,
    output logic      [TICK_W-1:0]    o_time_total,
    output logic      [CALL_W-1:0]    o_call_count,
    output logic      [DEPTH_W-1:0]   o_open_depth
);

    localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SAW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int EXT_W = TIME_BITS + TIME_IN_W;
    localparam int SUM_W = ((TIME_BITS > TICK_W) ? TIME_BITS : TICK_W) + 1;

    // control state
    t_state             r_state, n_state;
    t_req               r_req;
    logic [DEPTH_W-1:0] r_depth;

    // captured word
    logic [BW-1:0]        r_bkt;
    logic [TIME_BITS-1:0] r_now;

    // stack memory
    logic [BW-1:0]        r_stk_bkt  [STACK_DEPTH];
    logic [TIME_BITS-1:0] r_stk_time [STACK_DEPTH];
    logic [BW-1:0]        r_stk_bkt_q;
    logic [TIME_BITS-1:0] r_stk_time_q;

    // result register
    logic                r_out_valid;
    logic [BKT_IN_W-1:0] r_out_bkt;
    logic [TICK_W-1:0]   r_out_ticks;
    logic [CALL_W-1:0]   r_out_calls;
    logic [DEPTH_W-1:0]  r_out_depth;

    // combinational
    logic                 w_acc;
    t_req                 w_req;
    logic [EXT_W-1:0]     w_time_ext;
    logic [TIME_BITS-1:0] w_now;
    logic [BW-1:0]        w_bkt;
    logic                 w_has_top;
    logic                 w_can_push;
    logic                 w_can_restart;
    logic                 w_out_free;
    logic                 w_stk_re;
    logic                 w_stk_we_bkt;
    logic                 w_stk_we_time;
    logic [SAW-1:0]       w_stk_waddr;
    logic [SAW-1:0]       w_stk_raddr;
    t_bkt_ctl             w_bkt_ctl;
    logic [BW-1:0]        w_bkt_raddr;
    logic [BW-1:0]        w_bkt_waddr;
    logic [TICK_W-1:0]    w_wr_ticks;
    logic [CALL_W-1:0]    w_wr_calls;
    logic [TICK_W-1:0]    w_rd_ticks;
    logic [CALL_W-1:0]    w_rd_calls;
    logic [TIME_BITS-1:0] w_elapsed;
    logic [SUM_W-1:0]     w_sum;
    logic [TICK_W-1:0]    w_ticks_sat;
    logic [CALL_W-1:0]    w_calls_inc;
    logic                 w_load;

    // input decode
    assign w_acc      = i_valid && o_ready;
    assign w_req      = t_req'(i_req_type);
    assign w_time_ext = {{TIME_BITS{1'b0}}, i_time_now};
    assign w_now      = w_time_ext[TIME_BITS-1:0];
    assign w_bkt      = BW'(bkt_wrap(i_bucket, NUM_BUCKETS));

    // stack occupancy: top entry exists, room to push, parent to restart
    assign w_has_top     = (r_depth != '0) && (32'(r_depth) <= STACK_DEPTH);
    assign w_can_push    = 32'(r_depth) < STACK_DEPTH;
    assign w_can_restart = (r_depth > DEPTH_W'(1)) && (32'(r_depth) <= STACK_DEPTH + 1);

    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = (r_state == S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (w_req)
                        REQ_BEGIN: n_state = w_has_top ? S_STK : S_CALL;
                        REQ_END:   n_state = w_has_top ? S_STK : S_IDLE;
                        REQ_COUNT: n_state = S_CALL;
                        REQ_READ:  n_state = S_RESP;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_STK:     n_state = S_BILL;
            S_BILL:    n_state = (r_req == REQ_BEGIN) ? S_CALL_RD : S_IDLE;
            S_CALL_RD: n_state = S_CALL;
            S_CALL:    n_state = S_IDLE;
            S_RESP:    n_state = w_out_free ? S_IDLE : S_RESP;
            default:   n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: memory strobes and addresses
    always_comb begin
        w_stk_re      = 1'b0;
        w_stk_we_bkt  = 1'b0;
        w_stk_we_time = 1'b0;
        w_stk_raddr   = SAW'(r_depth - DEPTH_W'(1));
        w_stk_waddr   = SAW'(r_depth);
        w_bkt_ctl     = '0;
        w_bkt_raddr   = r_bkt;
        w_bkt_waddr   = r_bkt;
        w_wr_ticks    = w_rd_ticks;
        w_wr_calls    = w_rd_calls;
        w_load        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    w_stk_re    = w_has_top && ((w_req == REQ_BEGIN) || (w_req == REQ_END));
                    w_bkt_raddr = w_bkt;
                    unique case (w_req)
                        REQ_BEGIN: begin
                            w_stk_we_bkt    = w_can_push;
                            w_stk_we_time   = w_can_push;
                            w_bkt_ctl.rd_en = !w_has_top;
                        end
                        REQ_END: begin
                            // parent restarts its clock now
                            w_stk_waddr   = SAW'(r_depth - DEPTH_W'(2));
                            w_stk_we_time = w_can_restart;
                        end
                        REQ_COUNT, REQ_READ: w_bkt_ctl.rd_en = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_STK: begin
                w_bkt_raddr     = r_stk_bkt_q;
                w_bkt_ctl.rd_en = 1'b1;
            end
            S_BILL: begin
                w_bkt_waddr     = r_stk_bkt_q;
                w_wr_ticks      = w_ticks_sat;
                w_bkt_ctl.wr_en = 1'b1;
            end
            S_CALL_RD: w_bkt_ctl.rd_en = 1'b1;
            S_CALL: begin
                w_wr_calls      = w_calls_inc;
                w_bkt_ctl.wr_en = 1'b1;
            end
            S_RESP:  w_load = w_out_free;
            default: ;
        endcase
    end

    // elapsed ticks, wrapping difference, saturating accumulate
    assign w_elapsed   = r_now - r_stk_time_q;
    assign w_sum       = SUM_W'(w_rd_ticks) + SUM_W'(w_elapsed);
    assign w_ticks_sat = (w_sum > SUM_W'(TICKS_MAX)) ? TICKS_MAX : w_sum[TICK_W-1:0];
    assign w_calls_inc = (w_rd_calls == CALLS_MAX) ? CALLS_MAX : w_rd_calls + CALL_W'(1);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_acc) begin
                if (w_req == REQ_BEGIN && r_depth != DEPTH_MAX) begin
                    r_depth <= r_depth + DEPTH_W'(1);
                end else if (w_req == REQ_END && r_depth != '0) begin
                    r_depth <= r_depth - DEPTH_W'(1);
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // captured word
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_req <= w_req;
            r_bkt <= w_bkt;
            r_now <= w_now;
        end
    end

    // stack memory: one write port with per-field enables, registered read
    always_ff @(posedge i_clk) begin
        if (w_stk_we_bkt) begin
            r_stk_bkt[w_stk_waddr] <= w_bkt;
        end
        if (w_stk_we_time) begin
            r_stk_time[w_stk_waddr] <= w_now;
        end
        if (w_stk_re) begin
            r_stk_bkt_q  <= r_stk_bkt[w_stk_raddr];
            r_stk_time_q <= r_stk_time[w_stk_raddr];
        end
    end

    // bucket totals
    nrtp_bkt_mem #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .BW          (BW)
    ) u_bkt_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_bkt_ctl),
        .i_rd_addr  (w_bkt_raddr),
        .i_wr_addr  (w_bkt_waddr),
        .i_wr_ticks (w_wr_ticks),
        .i_wr_calls (w_wr_calls),
        .o_rd_ticks (w_rd_ticks),
        .o_rd_calls (w_rd_calls)
    );

    // result word
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_bkt   <= BKT_IN_W'(r_bkt);
            r_out_ticks <= w_rd_ticks;
            r_out_calls <= w_rd_calls;
            r_out_depth <= r_depth;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_bucket_out = r_out_bkt;
    assign o_time_total = r_out_ticks;
    assign o_call_count = r_out_calls;
    assign o_open_depth = r_out_depth;

endmodule

`default_nettype wire

/* rtl/nrtp_chk.sv */
// ---------------------------------------------------------------------------
// nrtp_chk
// Port-level checks of the profiler, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "nested_region_time_profiler_core_defines.svh"

module nrtp_chk
    import nrtp_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_valid,
    input wire logic                 o_ready,
    input wire logic [1:0]           i_req_type,
    input wire logic [BKT_IN_W-1:0]  i_bucket,
    input wire logic [TIME_IN_W-1:0] i_time_now,
    input wire logic                 o_valid,
    input wire logic                 i_ready,
    input wire logic [BKT_IN_W-1:0]  o_bucket_out,
    input wire logic [TICK_W-1:0]    o_time_total,
    input wire logic [CALL_W-1:0]    o_call_count,
    input wire logic [DEPTH_W-1:0]   o_open_depth
);

    logic w_acc;
    logic w_is_read;

    assign w_acc     = i_valid && o_ready;
    assign w_is_read = (i_req_type == REQ_READ);

    // a stalled result word holds
    `NRTP_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_bucket_out) && $stable(o_time_total) && $stable(o_call_count) && $stable(o_open_depth))

    // only reads produce a word
    `NRTP_ASSERT_NEXT(a_no_spurious, w_acc && !w_is_read && !o_valid, !o_valid)

    // a read with a free output is answered once the response state loads the result word
    `NRTP_ASSERT_IMPL(a_read_latency, w_acc && w_is_read && !o_valid, ##2 o_valid)

    // time is only billed to buckets that were begun
    `NRTP_ASSERT_IMPL(a_ticks_need_calls, o_valid, o_time_total == '0 || o_call_count != '0)

endmodule

bind nested_region_time_profiler_core nrtp_chk u_nrtp_chk (.*);

`default_nettype wire
